[hw/rtl/jsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Phase codes, character codes, the queued command word and the hex decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_HEX2,
        PH_RAW,
        PH_ERR
    } t_phase;

    // Characters seen in the input
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_LC_X   = 8'h78;

    // Control characters produced by the escapes
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam logic [2:0] RAW_COPY_COUNT = 3'd4;

    // One queued command: one or two data bytes, or the end of a string
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       is_end;
        logic       err;
    } t_cmd;

    // Bit 4 set: valid hex digit, bits 3:0 its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[hw/rtl/jsu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front: byte parser
// Accepts input bytes, tracks the escape phase and pushes commands.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_high_nibble, n_high_nibble;
    logic [2:0] r_raw_left, n_raw_left;

    logic fire;

    assign o_stall = i_full;
    assign fire    = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_OPEN;
            r_high_nibble <= 4'd0;
            r_raw_left    <= 3'd0;
        end else begin
            r_phase       <= n_phase;
            r_high_nibble <= n_high_nibble;
            r_raw_left    <= n_raw_left;
        end
    end

    always_comb begin
        logic [4:0] hx;
        logic [2:0] dec_left;
        hx            = hex_digit(i_in_byte);
        dec_left      = (r_raw_left != 3'd0) ? r_raw_left - 3'd1 : 3'd0;
        n_phase       = r_phase;
        n_high_nibble = r_high_nibble;
        n_raw_left    = r_raw_left;
        o_push        = 1'b0;
        o_cmd         = '0;
        if (fire) begin
            if (i_in_last) begin
                o_push        = 1'b1;
                o_cmd.is_end  = 1'b1;
                o_cmd.err     = !((r_phase == PH_BODY || r_phase == PH_RAW)
                                  && i_in_byte == CH_QUOTE);
                n_phase       = PH_OPEN;
                n_high_nibble = 4'd0;
                n_raw_left    = 3'd0;
            end else begin
                case (r_phase)
                    PH_OPEN: begin
                        n_phase = (i_in_byte == CH_QUOTE) ? PH_BODY : PH_ERR;
                    end
                    PH_BODY: begin
                        if (i_in_byte == CH_QUOTE) begin
                            n_phase = PH_ERR;
                        end else if (i_in_byte == CH_BSLASH) begin
                            n_phase = PH_ESC;
                        end else begin
                            o_push   = 1'b1;
                            o_cmd.b0 = i_in_byte;
                        end
                    end
                    PH_ESC: begin
                        n_phase  = PH_BODY;
                        o_push   = 1'b1;
                        case (i_in_byte)
                            CH_BSLASH: o_cmd.b0 = CH_BSLASH;
                            CH_QUOTE:  o_cmd.b0 = CH_QUOTE;
                            CH_SLASH:  o_cmd.b0 = CH_SLASH;
                            CH_LC_B:   o_cmd.b0 = CH_BS;
                            CH_LC_F:   o_cmd.b0 = CH_FF;
                            CH_LC_R:   o_cmd.b0 = CH_CR;
                            CH_LC_N:   o_cmd.b0 = CH_LF;
                            CH_LC_T:   o_cmd.b0 = CH_TAB;
                            CH_LC_U: begin
                                o_cmd.two  = 1'b1;
                                o_cmd.b0   = CH_BSLASH;
                                o_cmd.b1   = CH_LC_U;
                                n_raw_left = RAW_COPY_COUNT;
                                n_phase    = PH_RAW;
                            end
                            CH_LC_X: begin
                                o_push  = 1'b0;
                                n_phase = PH_HEX1;
                            end
                            default: begin
                                o_push  = 1'b0;
                                n_phase = PH_ERR;
                            end
                        endcase
                    end
                    PH_HEX1: begin
                        if (hx[4]) begin
                            n_high_nibble = hx[3:0];
                            n_phase       = PH_HEX2;
                        end else begin
                            n_phase = PH_ERR;
                        end
                    end
                    PH_HEX2: begin
                        if (hx[4]) begin
                            o_push   = 1'b1;
                            o_cmd.b0 = {r_high_nibble, hx[3:0]};
                            n_phase  = PH_BODY;
                        end else begin
                            n_phase = PH_ERR;
                        end
                        n_high_nibble = 4'd0;
                    end
                    PH_RAW: begin
                        o_push     = 1'b1;
                        o_cmd.b0   = i_in_byte;
                        n_raw_left = dec_left;
                        if (dec_left == 3'd0) begin
                            n_phase = PH_BODY;
                        end
                    end
                    default: begin
                        n_phase = PH_ERR;
                    end
                endcase
            end
        end
    end

endmodule

[hw/rtl/jsu_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_queue: command queue
// Small register FIFO between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[hw/rtl/jsu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back: result sequencer
// Expands queued commands into result words and holds the output register.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_string_end,
    output logic       o_string_error,
    output logic       o_run_last
);

    logic       r_valid, n_valid;
    logic       r_half, n_half;
    logic [7:0] r_byte, n_byte;
    logic       r_byte_valid, n_byte_valid;
    logic       r_end, n_end;
    logic       r_err, n_err;
    logic       r_run_last, n_run_last;

    logic load_ok;

    assign load_ok = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_byte_valid <= n_byte_valid;
        r_end        <= n_end;
        r_err        <= n_err;
        r_run_last   <= n_run_last;
    end

    always_comb begin
        n_valid      = r_valid;
        n_half       = r_half;
        n_byte       = r_byte;
        n_byte_valid = r_byte_valid;
        n_end        = r_end;
        n_err        = r_err;
        n_run_last   = r_run_last;
        o_pop        = 1'b0;
        if (load_ok) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_byte_valid = !i_head.is_end;
                n_end        = i_head.is_end;
                n_err        = i_head.is_end && i_head.err;
                if (i_head.is_end) begin
                    n_byte = 8'd0;
                end else begin
                    n_byte = r_half ? i_head.b1 : i_head.b0;
                end
                if (i_head.two && !r_half) begin
                    // first of a pair: keep the command at the head
                    n_half     = 1'b1;
                    n_run_last = 1'b0;
                end else begin
                    n_half     = 1'b0;
                    n_run_last = 1'b1;
                    o_pop      = 1'b1;
                end
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_byte;
    assign o_byte_valid   = r_byte_valid;
    assign o_string_end   = r_end;
    assign o_string_error = r_err;
    assign o_run_last     = r_run_last;

endmodule

[hw/rtl/json_string_unescape.sv]
`timescale 1ns / 1ps
// A result word is held in the command queue, then in the output register at o_valid.
// Throughput: one input byte per cycle unless o_stall; a \u escape yields two words,
//   which the result sequencer sends in turn while the command queue absorbs input.
// Input stalls only while the command queue (QUEUE_DEPTH entries) is full.
// Reset: synchronous, active low; clears the parse phase, the queue and o_valid.
// ----------------------------------------------------------------------------
// json_string_unescape: streaming decoder for one quoted JSON string
// Front parser classifies each byte and pushes commands; a back sequencer
// turns each command into one or two result words behind an output register.
// ----------------------------------------------------------------------------
module json_string_unescape
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    // result word channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_string_end,
    output logic       o_string_error,
    output logic       o_run_last
);

    // Commands carry everything one input byte produces: a data byte, the
    // two-byte \u pair, or the end-of-string word with its error flag.
    // Bytes that produce nothing (quotes, escape prefixes, ignored bytes
    // after an error) push no command at all.
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_full    (q_full),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    // Decouple the parser from the output side so a stalled consumer or a
    // two-word \u result does not hold up byte intake until the queue fills.
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty)
    );

    // Emit one word per cycle unless stalled; pop the queue after a command's last word.
    jsu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_cmd),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_string_end   (o_string_end),
        .o_string_error (o_string_error),
        .o_run_last     (o_run_last)
    );

endmodule

[hw/rtl/jsu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker: port-level assertions for the JSON string unescaper
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_string_end,
    input logic       o_string_error,
    input logic       o_run_last
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_byte_valid)
            && $stable(o_string_end) && $stable(o_string_error) && $stable(o_run_last))
        else $error("result word changed while stalled");

    // The second word of a pair follows right after the first is taken.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_run_last |=> o_valid && o_byte_valid)
        else $error("second word of a pair missing");

    // End words are alone, carry no byte; data words carry no error.
    a_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_string_end ? (o_run_last && !o_byte_valid && o_out_byte == 8'd0)
                                  : (o_byte_valid && !o_string_error)))
        else $error("malformed result word");

    // Reset drops the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_byte     (o_out_byte),
    .o_byte_valid   (o_byte_valid),
    .o_string_end   (o_string_end),
    .o_string_error (o_string_error),
    .o_run_last     (o_run_last)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for json_string_unescape
// Feeds quoted strings byte by byte, decodes them in a software model of the
// unescaper and compares every result word field by field, under random and
// long stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import jsu_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 11;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    // Escape letters that decode to a single byte
    localparam logic [7:0] SIMPLE_ESCAPES [8] = '{
        CH_BSLASH, CH_QUOTE, CH_SLASH, CH_LC_B, CH_LC_F, CH_LC_R, CH_LC_N, CH_LC_T
    };

    // One result word as it leaves the block
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
        logic       string_error;
        logic       run_last;
    } t_word;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic       o_stall;
    logic [7:0] i_in_byte      = 8'h00;
    logic       i_in_last      = 1'b0;
    logic       o_valid;
    logic       i_stall        = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_string_end;
    logic       o_string_error;
    logic       o_run_last;

    // Decoder model state
    t_phase     scan_phase     = PH_OPEN;
    logic [3:0] hex_hi         = 4'd0;
    logic [2:0] raw_bytes_left = 3'd0;

    t_word      expected_words [$];
    logic [7:0] text_q [$];

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int hold_cycles_left = 0;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int words_checked  = 0;
    int bytes_sent     = 0;
    int strings_sent   = 0;
    int bad_strings    = 0;
    int input_stalls   = 0;

    json_string_unescape i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_string_end   (o_string_end),
        .o_string_error (o_string_error),
        .o_run_last     (o_run_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Software decoder
    // ------------------------------------------------------------------------

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
        end else if (c >= "a" && c <= "f") begin
            return int'(c) - int'("a") + 10;
        end else if (c >= "A" && c <= "F") begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    function automatic t_word data_word(input logic [7:0] b);
        t_word w;
        w = '0;
        w.out_byte   = b;
        w.byte_valid = 1'b1;
        return w;
    endfunction

    // Advance the model by one accepted byte and queue the words it yields.
    // The last word of each byte carries run_last.
    task automatic decode_byte(input logic [7:0] c, input logic is_last);
        t_word outw [2];
        int    n;
        int    v;
        n = 0;
        if (is_last) begin
            outw[0] = '0;
            outw[0].string_end   = 1'b1;
            outw[0].string_error = !((scan_phase == PH_BODY || scan_phase == PH_RAW)
                                     && c == CH_QUOTE);
            if (outw[0].string_error) begin
                bad_strings++;
            end
            n = 1;
            scan_phase     = PH_OPEN;
            hex_hi         = 4'd0;
            raw_bytes_left = 3'd0;
        end else begin
            case (scan_phase)
                PH_OPEN: begin
                    scan_phase = (c == CH_QUOTE) ? PH_BODY : PH_ERR;
                end
                PH_BODY: begin
                    if (c == CH_QUOTE) begin
                        scan_phase = PH_ERR;
                    end else if (c == CH_BSLASH) begin
                        scan_phase = PH_ESC;
                    end else begin
                        outw[0] = data_word(c);
                        n = 1;
                    end
                end
                PH_ESC: begin
                    scan_phase = PH_BODY;
                    n = 1;
                    case (c)
                        CH_BSLASH: outw[0] = data_word(CH_BSLASH);
                        CH_QUOTE:  outw[0] = data_word(CH_QUOTE);
                        CH_SLASH:  outw[0] = data_word(CH_SLASH);
                        CH_LC_B:   outw[0] = data_word(CH_BS);
                        CH_LC_F:   outw[0] = data_word(CH_FF);
                        CH_LC_R:   outw[0] = data_word(CH_CR);
                        CH_LC_N:   outw[0] = data_word(CH_LF);
                        CH_LC_T:   outw[0] = data_word(CH_TAB);
                        CH_LC_U: begin
                            // pass the escape through and copy what follows raw
                            outw[0]        = data_word(CH_BSLASH);
                            outw[1]        = data_word(CH_LC_U);
                            n              = 2;
                            raw_bytes_left = RAW_COPY_COUNT;
                            scan_phase     = PH_RAW;
                        end
                        CH_LC_X: begin
                            n          = 0;
                            scan_phase = PH_HEX1;
                        end
                        default: begin
                            n          = 0;
                            scan_phase = PH_ERR;
                        end
                    endcase
                end
                PH_HEX1: begin
                    v = hex_value(c);
                    if (v < 0) begin
                        scan_phase = PH_ERR;
                    end else begin
                        hex_hi     = v[3:0];
                        scan_phase = PH_HEX2;
                    end
                end
                PH_HEX2: begin
                    v = hex_value(c);
                    if (v < 0) begin
                        scan_phase = PH_ERR;
                    end else begin
                        outw[0]    = data_word({hex_hi, v[3:0]});
                        n          = 1;
                        scan_phase = PH_BODY;
                    end
                    hex_hi = 4'd0;
                end
                PH_RAW: begin
                    outw[0] = data_word(c);
                    n = 1;
                    if (raw_bytes_left > 0) begin
                        raw_bytes_left = raw_bytes_left - 3'd1;
                    end
                    if (raw_bytes_left == 0) begin
                        scan_phase = PH_BODY;
                    end
                end
                default: begin
                    scan_phase = PH_ERR;
                end
            endcase
        end
        if (n > 0) begin
            outw[n - 1].run_last = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            expected_words.push_back(outw[k]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking: one word per accepted handshake on the output side
    // ------------------------------------------------------------------------

    function automatic void note_mismatch(input string what, input t_word want,
                                          input t_word got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected byte=%02h bv=%b end=%b err=%b last=%b",
                     $realtime, what,
                     want.out_byte, want.byte_valid, want.string_end,
                     want.string_error, want.run_last);
            $display("    got byte=%02h bv=%b end=%b err=%b last=%b",
                     got.out_byte, got.byte_valid, got.string_end,
                     got.string_error, got.run_last);
        end
    endfunction

    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (i_rst_n) begin
            if (i_valid && o_stall) begin
                input_stalls++;
            end
            if (o_valid && !i_stall) begin
                got.out_byte     = o_out_byte;
                got.byte_valid   = o_byte_valid;
                got.string_end   = o_string_end;
                got.string_error = o_string_error;
                got.run_last     = o_run_last;
                words_checked++;
                if (expected_words.size() == 0) begin
                    note_mismatch("unexpected word", '0, got);
                end else begin
                    want = expected_words.pop_front();
                    if (got.out_byte !== want.out_byte
                        || got.byte_valid !== want.byte_valid
                        || got.string_end !== want.string_end
                        || got.string_error !== want.string_error
                        || got.run_last !== want.run_last) begin
                        note_mismatch("word mismatch", want, got);
                    end
                end
            end
        end
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: hold off for a counted stretch when asked, otherwise stall
    // at random with the current percentage.
    always @(negedge i_clk) begin
        if (hold_cycles_left > 0) begin
            i_stall <= 1'b1;
            hold_cycles_left = hold_cycles_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one byte, idling first at random; predict once it is taken.
    // Each call starts at the next falling edge, so valid gets one update there.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= is_last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        decode_byte(b, is_last);
        bytes_sent++;
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Send text_q as one string; optionally pause for a full drain mid-string
    task automatic send_queue(input int pause_at);
        for (int k = 0; k < text_q.size(); k++) begin
            if (k == pause_at) begin
                wait_drain();
            end
            send_byte(text_q[k], k == text_q.size() - 1);
        end
        strings_sent++;
    endtask

    task automatic send_text(input string s);
        text_q = {};
        for (int k = 0; k < s.len(); k++) begin
            text_q.push_back(s[k]);
        end
        send_queue(-1);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) begin
            return 8'h30 + {4'd0, nib};
        end
        return (upper ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
    endfunction

    // Build a well-formed string from random tokens, then now and then break
    // it: overwrite a byte, cut it short, or replace it with plain noise.
    task automatic build_random_string();
        int         ntok;
        int         kind;
        int         nraw;
        logic [7:0] c;
        text_q = {};
        text_q.push_back(CH_QUOTE);
        ntok = $urandom_range(12);
        for (int k = 0; k < ntok; k++) begin
            kind = $urandom_range(9);
            if (kind <= 3) begin
                do begin
                    c = 8'($urandom_range(255));
                end while (c == CH_QUOTE || c == CH_BSLASH);
                text_q.push_back(c);
            end else if (kind <= 5) begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(SIMPLE_ESCAPES[$urandom_range(7)]);
            end else if (kind <= 7) begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(CH_LC_X);
                text_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
                text_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end else begin
                // a unicode escape at the very end may be cut short by the quote
                text_q.push_back(CH_BSLASH);
                text_q.push_back(CH_LC_U);
                nraw = (k == ntok - 1) ? $urandom_range(4) : 4;
                repeat (nraw) text_q.push_back(8'($urandom_range(255)));
            end
        end
        text_q.push_back(CH_QUOTE);
        kind = $urandom_range(99);
        if (kind < 8) begin
            text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
        end else if (kind < 12) begin
            nraw = $urandom_range(1, text_q.size());
            while (text_q.size() > nraw) begin
                text_q.delete(text_q.size() - 1);
            end
        end else if (kind < 15) begin
            text_q = {};
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked strings: every escape, byte extremes and each error path
    task automatic test_directed();
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        send_text("\"\"");                              // empty string
        send_text("\"");                                // one byte only
        send_text("\"a\\\\\\\"\\/\\b\\f\\r\\n\\t\"");   // all simple escapes
        send_text("\"\\x41\\xfF\\x00\\xa0\"");          // hex, both cases
        text_q = '{CH_QUOTE, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_QUOTE};
        send_queue(-1);                                 // raw byte extremes
        send_text("\"\\uAB\"\\\\Z\"");                  // quote copied raw after \u
        send_text("\"\\u1\"");                          // \u copy cut short: clean
        send_text("abc\"");                             // no opening quote
        send_text("\"ab");                              // last byte not a quote
        send_text("\"a\"b\"");                          // bare quote inside
        send_text("\"\\q\"");                           // unknown escape
        send_text("\"\\xg1\"");                         // bad first hex digit
        send_text("\"\\x1g\"");                         // bad second hex digit
        send_text("\"\\\"");                            // dangling backslash
        send_text("\"\\x4\"");                          // unfinished hex escape
        wait_drain();
    endtask

    task automatic test_random_strings(input int idle_pct, input int stall_pct,
                                       input int nbytes);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = bytes_sent;
        while (bytes_sent - start < nbytes) begin
            build_random_string();
            send_queue(-1);
        end
        wait_drain();
    endtask

    // Long receiver hold-off to fill the queue and stall the input, then a
    // sender pause mid-string until everything has drained.
    task automatic test_pressure();
        send_idle_pct    = 0;
        recv_stall_pct   = 10;
        hold_cycles_left = 300;
        repeat (12) begin
            build_random_string();
            send_queue(-1);
        end
        repeat (3) begin
            build_random_string();
            send_queue(text_q.size() / 2);
        end
        wait_drain();
    endtask

    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_strings(20, 67, 320);
        test_random_strings(67, 20, 320);
        test_random_strings(0, 0, 320);
        test_pressure();

        // let any stray word show up before judging
        wait_drain();
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d strings (%0d malformed), %0d bytes in, %0d words out",
                 strings_sent, bad_strings, bytes_sent, words_checked);
        $display("input stalled on %0d cycles, %0d mismatches",
                 input_stalls, mismatch_count);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
